[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[hw/rtl/ciop_pkg.sv]
// Types and constants of the console I/O port unit.
`default_nettype none

package ciop_pkg;

    // Field widths
    localparam int PORT_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int LINE_W      = 9;
    localparam int ELAPSED_W   = 11;
    localparam int HSCALE_W    = 8;
    localparam int LCYC_W      = 10;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;
    localparam int KIND_W      = 2;
    localparam int ROUTE_W     = 3;

    // Divider widths: dividend is the elapsed count scaled by 256
    localparam int DIV_NUM_W   = ELAPSED_W + HSCALE_W;
    localparam int DIV_DEN_W   = LCYC_W;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_LATCH = 2'd2
    } kind_t;

    // Result routes
    typedef enum logic [ROUTE_W-1:0] {
        ROUTE_LOCAL      = 3'd0,
        ROUTE_VDP_DATA_W = 3'd1,
        ROUTE_VDP_CTRL_W = 3'd2,
        ROUTE_PSG_W      = 3'd3,
        ROUTE_VDP_DATA_R = 3'd4,
        ROUTE_VDP_STAT_R = 3'd5
    } route_t;

    // Port ranges, from the top two address bits
    localparam logic [1:0] RANGE_LOW  = 2'b00;
    localparam logic [1:0] RANGE_CNT  = 2'b01;
    localparam logic [1:0] RANGE_VDP  = 2'b10;
    localparam logic [1:0] RANGE_PAD  = 2'b11;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNTRY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LCYC    = 2'd2;

    localparam logic [LCYC_W-1:0] LCYC_RESET = 10'd228;

endpackage : ciop_pkg

`default_nettype wire

[hw/rtl/ciop_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module ciop_div #(
    parameter int NUM_W = ciop_pkg::DIV_NUM_W,
    parameter int DEN_W = ciop_pkg::DIV_DEN_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [NUM_W-1:0] quo_reg,  quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   partial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Trial subtract of the shifted remainder
    assign partial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = partial >= {1'b0, den_reg};
    assign diff    = partial - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : ciop_div

`default_nettype wire

[hw/rtl/console_io_port_unit.sv]
// Top level of the console I/O port unit: port decode, local registers, sequencer.
//
//  Channel   Dir  Handshake          Payload
//  s_        in   s_tvalid/s_tready  s_tuser kind, s_tdata port..cycles_left
//  m_        out  m_tvalid/m_tready  m_tuser route, m_tdata read_data, route_data
//  cfg_      in   cfg_we             cfg_addr index, cfg_wdata value
//
// An H counter read goes from the accept to serial division, one quotient bit a
// cycle; the sequencer sees done and builds the result in resolve. Any other word
// goes from the accept straight to resolve. No new word is taken until the result
// is built. Reset (synchronous, aresetn low) clears the local registers and loads
// the configuration defaults. A stalled result holds in the output register; the
// next word is taken in and waits in resolve for the slot.
`default_nettype none

module console_io_port_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input words
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // port, write_data, pad_buttons, scan_line, cycles_left (from bit 0 up)
    input  wire logic [ciop_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind
    input  wire logic [ciop_pkg::KIND_W-1:0]         s_tuser,
    // Result words
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // read_data, route_data (from bit 0 up)
    output logic      [ciop_pkg::M_TDATA_W-1:0]      m_tdata,
    // route
    output logic      [ciop_pkg::ROUTE_W-1:0]        m_tuser,
    // Configuration writes
    input  wire logic                                cfg_we,
    input  wire logic [ciop_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [ciop_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_RESOLVE
    } state_t;

    // Fixed local port addresses
    localparam logic [7:0] PORT_SYSCTRL = 8'h00;
    localparam logic [7:0] PORT_CONST_A = 8'h01;
    localparam logic [7:0] PORT_CONST_B = 8'h02;
    localparam logic [7:0] PORT_CONST_C = 8'h03;
    localparam logic [7:0] PORT_CONST_D = 8'h04;
    localparam logic [7:0] PORT_CONST_E = 8'h05;
    localparam logic [7:0] PORT_STEREO  = 8'h06;

    localparam logic [7:0] VJUMP_WIDE = 8'hEA;
    localparam logic [7:0] VJUMP_STD  = 8'hDA;
    localparam logic [8:0] VJUMP_BACK = 9'd6;
    localparam logic [3:0] NAT_MATCH  = 4'h5;
    localparam logic [3:0] NAT_HIGH   = 4'hF;

    // Input word fields
    logic [ciop_pkg::PORT_W-1:0]    in_port;
    logic [ciop_pkg::BYTE_W-1:0]    in_wdata;
    logic [ciop_pkg::BYTE_W-1:0]    in_pad;
    logic [ciop_pkg::LINE_W-1:0]    in_line;
    logic [ciop_pkg::ELAPSED_W-1:0] in_left;

    assign in_port  = s_tdata[7:0];
    assign in_wdata = s_tdata[15:8];
    assign in_pad   = s_tdata[23:16];
    assign in_line  = s_tdata[32:24];
    assign in_left  = s_tdata[43:33];

    state_t state_reg, state_next;

    // Configuration
    logic                          japan_reg;
    logic                          wide_reg;
    logic [ciop_pkg::LCYC_W-1:0]   lcyc_reg;

    // Local registers
    logic [7:0] pad_latch_reg,  pad_latch_next;
    logic [7:0] io_ctrl_reg,    io_ctrl_next;
    logic [7:0] stereo_reg,     stereo_next;
    logic [7:0] sys_ctrl_reg,   sys_ctrl_next;

    // Captured word
    logic [ciop_pkg::KIND_W-1:0]   kind_reg;
    logic [ciop_pkg::PORT_W-1:0]   port_reg;
    logic [ciop_pkg::BYTE_W-1:0]   wdata_reg;
    logic [ciop_pkg::BYTE_W-1:0]   pad_reg;
    logic [ciop_pkg::LINE_W-1:0]   line_reg;

    // Output register
    logic                          m_valid_reg, m_valid_next;
    logic [7:0]                    rdata_reg,   rdata_next;
    logic [7:0]                    rtdata_reg,  rtdata_next;
    logic [ciop_pkg::ROUTE_W-1:0]  route_reg,   route_next;

    logic                          s_fire;
    logic                          is_hread;
    logic                          out_free;
    logic                          div_start;
    logic                          div_done;
    logic [ciop_pkg::DIV_NUM_W-1:0] div_num;
    logic [ciop_pkg::DIV_DEN_W-1:0] div_den;
    logic [ciop_pkg::DIV_NUM_W-1:0] div_quo;
    logic signed [ciop_pkg::ELAPSED_W:0] elapsed;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // H counter reads go to the divider straight from the input word
    assign is_hread = (s_tuser == ciop_pkg::KIND_READ) &&
                      (in_port[7:6] == ciop_pkg::RANGE_CNT) && in_port[0];
    assign div_start = s_fire && is_hread;

    // Elapsed line cycles, clamped at zero, scaled by 256
    assign elapsed = $signed({2'b00, lcyc_reg}) -
                     $signed({in_left[ciop_pkg::ELAPSED_W-1], in_left});
    assign div_num = elapsed[ciop_pkg::ELAPSED_W] ? '0 :
                     {elapsed[ciop_pkg::ELAPSED_W-1:0], {ciop_pkg::HSCALE_W{1'b0}}};
    assign div_den = (lcyc_reg == '0) ? ciop_pkg::DIV_DEN_W'(1) : lcyc_reg;

    ciop_div #(
        .NUM_W (ciop_pkg::DIV_NUM_W),
        .DEN_W (ciop_pkg::DIV_DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Read-side helpers on the captured word
    logic [7:0] v_count;
    logic [7:0] v_jump;
    logic [8:0] v_back;
    logic [7:0] pad_a;
    logic [7:0] pad_b;
    logic [7:0] low_port;

    assign v_jump  = wide_reg ? VJUMP_WIDE : VJUMP_STD;
    assign v_back  = line_reg - VJUMP_BACK;
    assign v_count = (line_reg <= {1'b0, v_jump}) ? line_reg[7:0] : v_back[7:0];

    assign pad_a = {2'b11, ~pad_latch_reg[6], ~(pad_latch_reg[5] | pad_latch_reg[4]),
                    ~pad_latch_reg[3:0]};

    always_comb begin
        pad_b = 8'hFF;
        if (!japan_reg && io_ctrl_reg[3:0] == NAT_MATCH && io_ctrl_reg[7:4] != NAT_HIGH) begin
            pad_b = 8'h3F;
        end
    end

    always_comb begin
        unique case (port_reg)
            PORT_SYSCTRL: low_port = sys_ctrl_reg;
            PORT_CONST_A: low_port = 8'h7F;
            PORT_CONST_B: low_port = 8'hFF;
            PORT_CONST_C: low_port = 8'h00;
            PORT_CONST_D: low_port = 8'hFF;
            PORT_CONST_E: low_port = 8'h00;
            PORT_STEREO:  low_port = stereo_reg;
            default:      low_port = 8'hFF;
        endcase
    end

    // Sequencer and result build
    always_comb begin
        state_next     = state_reg;
        pad_latch_next = pad_latch_reg;
        io_ctrl_next   = io_ctrl_reg;
        stereo_next    = stereo_reg;
        sys_ctrl_next  = sys_ctrl_reg;
        m_valid_next   = m_valid_reg;
        rdata_next     = rdata_reg;
        rtdata_next    = rtdata_reg;
        route_next     = route_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = is_hread ? ST_DIVIDE : ST_RESOLVE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    rdata_next   = 8'hFF;
                    rtdata_next  = 8'h00;
                    route_next   = ciop_pkg::ROUTE_LOCAL;
                    unique case (kind_reg)
                        ciop_pkg::KIND_READ: begin
                            unique case (port_reg[7:6])
                                ciop_pkg::RANGE_VDP: begin
                                    route_next = port_reg[0] ? ciop_pkg::ROUTE_VDP_STAT_R
                                                             : ciop_pkg::ROUTE_VDP_DATA_R;
                                end
                                ciop_pkg::RANGE_CNT: begin
                                    rdata_next = port_reg[0] ? div_quo[7:0] : v_count;
                                end
                                ciop_pkg::RANGE_PAD: begin
                                    rdata_next = port_reg[0] ? pad_b : pad_a;
                                end
                                default: begin
                                    rdata_next = low_port;
                                end
                            endcase
                        end
                        ciop_pkg::KIND_WRITE: begin
                            unique case (port_reg[7:6])
                                ciop_pkg::RANGE_VDP: begin
                                    route_next  = port_reg[0] ? ciop_pkg::ROUTE_VDP_CTRL_W
                                                              : ciop_pkg::ROUTE_VDP_DATA_W;
                                    rtdata_next = wdata_reg;
                                end
                                ciop_pkg::RANGE_CNT: begin
                                    route_next  = ciop_pkg::ROUTE_PSG_W;
                                    rtdata_next = wdata_reg;
                                end
                                ciop_pkg::RANGE_LOW: begin
                                    if (port_reg == PORT_STEREO) begin
                                        stereo_next = wdata_reg;
                                    end else if (port_reg[0]) begin
                                        io_ctrl_next = wdata_reg;
                                    end
                                end
                                default: begin
                                    // high range writes are dropped
                                end
                            endcase
                        end
                        ciop_pkg::KIND_LATCH: begin
                            pad_latch_next = pad_reg;
                            sys_ctrl_next  = {~pad_reg[7], 7'h7F};
                        end
                        default: begin
                            // unknown kind: defaults only
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            pad_latch_reg <= '0;
            io_ctrl_reg   <= '0;
            stereo_reg    <= '0;
            sys_ctrl_reg  <= '0;
            japan_reg     <= 1'b0;
            wide_reg      <= 1'b0;
            lcyc_reg      <= ciop_pkg::LCYC_RESET;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            pad_latch_reg <= pad_latch_next;
            io_ctrl_reg   <= io_ctrl_next;
            stereo_reg    <= stereo_next;
            sys_ctrl_reg  <= sys_ctrl_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    ciop_pkg::CFG_COUNTRY: japan_reg <= cfg_wdata[0];
                    ciop_pkg::CFG_WIDE:    wide_reg  <= cfg_wdata[0];
                    ciop_pkg::CFG_LCYC:    lcyc_reg  <= cfg_wdata[ciop_pkg::LCYC_W-1:0];
                    default: begin
                        // no register at this index
                    end
                endcase
            end
        end
        rdata_reg  <= rdata_next;
        rtdata_reg <= rtdata_next;
        route_reg  <= route_next;
        if (s_fire) begin
            kind_reg  <= s_tuser;
            port_reg  <= in_port;
            wdata_reg <= in_wdata;
            pad_reg   <= in_pad;
            line_reg  <= in_line;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {rtdata_reg, rdata_reg};
    assign m_tuser  = route_reg;

endmodule : console_io_port_unit

`default_nettype wire

[hw/rtl/ciop_checker.sv]
// Port-level checks of the console I/O port unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ciop_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [ciop_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [ciop_pkg::ROUTE_W-1:0]   m_tuser
);

    // Stalled result word holds
    `ASSERT_CLK(a_out_hold, aclk, aresetn,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)),
        "stalled result changed")

    // At most one word in the sequencer: input side closes after an accept
    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn,
        (s_tvalid && s_tready) |=> !s_tready, "input taken while busy")

    // Routes beyond the status read do not exist
    `ASSERT_NEVER(a_route_range, aclk, aresetn,
        m_tvalid && (m_tuser > ciop_pkg::ROUTE_VDP_STAT_R), "route code out of range")

    // Forwarded writes carry no local read byte
    `ASSERT_CLK(a_write_read_ff, aclk, aresetn,
        (m_tvalid && (m_tuser == ciop_pkg::ROUTE_VDP_DATA_W ||
                      m_tuser == ciop_pkg::ROUTE_VDP_CTRL_W ||
                      m_tuser == ciop_pkg::ROUTE_PSG_W)) |-> (m_tdata[7:0] == 8'hFF),
        "routed write with read byte")

    // Local and VDP read words carry no forwarded byte
    `ASSERT_CLK(a_read_no_fwd, aclk, aresetn,
        (m_tvalid && (m_tuser == ciop_pkg::ROUTE_LOCAL ||
                      m_tuser == ciop_pkg::ROUTE_VDP_DATA_R ||
                      m_tuser == ciop_pkg::ROUTE_VDP_STAT_R)) |-> (m_tdata[15:8] == 8'h00),
        "forward byte on non-write route")

endmodule : ciop_checker

bind console_io_port_unit ciop_checker u_ciop_checker (.*);

`default_nettype wire
